/* src/stick_deadzone_direction_buttons_macros.svh */
// assertion macros for the stick dead zone block
// used by the top level; needs signals named clock and reset in scope
`ifndef STICK_DEADZONE_DIRECTION_BUTTONS_MACROS_SVH
`define STICK_DEADZONE_DIRECTION_BUTTONS_MACROS_SVH

// clocked check, off during reset
`define SDDB_CHECK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds during reset
`define SDDB_CHECK_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/sddb_pkg.sv */
// shared types and constants for the stick dead zone block
// no dependencies
package sddb_pkg;

   localparam int unsigned COORD_W   = 9;
   localparam int unsigned ADJ_W     = 10;
   localparam int unsigned BTN_IN_W  = 32;
   localparam int unsigned BTN_W     = 28;
   localparam int unsigned RADIUS_W  = 9;
   localparam int unsigned SLOPE_W   = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 16;

   localparam int unsigned LEN_W     = 18;
   localparam int unsigned RAD_W     = 32;
   localparam int unsigned ROOT_W    = 16;
   localparam int unsigned LEN_SHIFT = 14;
   localparam int unsigned R_SHIFT   = 7;

   localparam logic [RADIUS_W-1:0] INNER_RESET = 9'd40;
   localparam logic [RADIUS_W-1:0] OUTER_RESET = 9'd145;
   localparam logic [SLOPE_W-1:0]  SLOPE_RESET = 16'd443;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INNER = 2'd0,
      CSR_OUTER = 2'd1,
      CSR_SLOPE = 2'd2
   } csr_index_type;

endpackage

/* src/sddb_sqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on sddb_pkg
module sddb_sqrt #(
   parameter int unsigned SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [sddb_pkg::RAD_W-1:0]  radicand,
   input  logic [SIDE_W-1:0]           side_in,
   output logic [sddb_pkg::ROOT_W-1:0] root,
   output logic [SIDE_W-1:0]           side_out
);
   import sddb_pkg::*;

   localparam int unsigned REM_W = ROOT_W + 2;
   localparam int unsigned SH_W  = REM_W + 2;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_step
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [SH_W-1:0]   shifted;
      logic [SH_W-1:0]   trial;
      logic [SH_W:0]     diff;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
         assign side_prev = side_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      assign shifted = {rem_prev, rad_prev[RAD_W-1 -: 2]};
      assign trial   = {2'b00, root_prev, 2'b01};
      assign diff    = {1'b0, shifted} - {1'b0, trial};

      always_ff @(posedge clock) begin
         if (en) begin
            if (!diff[SH_W]) begin
               rem_ff[i]  <= diff[REM_W-1:0];
               root_ff[i] <= {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[i]  <= shifted[REM_W-1:0];
               root_ff[i] <= {root_prev[ROOT_W-2:0], 1'b0};
            end
            rad_ff[i]  <= {rad_prev[RAD_W-3:0], 2'b00};
            side_ff[i] <= side_prev;
         end
      end
   end

   assign root     = root_ff[ROOT_W-1];
   assign side_out = side_ff[ROOT_W-1];

endmodule

/* src/sddb_div.sv */
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on sddb_pkg
module sddb_div #(
   parameter int unsigned NUM_W  = 24,
   parameter int unsigned DEN_W  = 16,
   parameter int unsigned SIDE_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic [NUM_W-1:0]  quo,
   output logic [SIDE_W-1:0] side_out
);
   import sddb_pkg::*;

   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  num_ff  [NUM_W];
   logic [NUM_W-1:0]  quo_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_step
      logic [DEN_W-1:0]  rem_prev;
      logic [NUM_W-1:0]  num_prev;
      logic [NUM_W-1:0]  quo_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    shifted;
      logic [DEN_W+1:0]  diff;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign num_prev  = num;
         assign quo_prev  = '0;
         assign den_prev  = den;
         assign side_prev = side_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign num_prev  = num_ff[i-1];
         assign quo_prev  = quo_ff[i-1];
         assign den_prev  = den_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      assign shifted = {rem_prev, num_prev[NUM_W-1]};
      assign diff    = {1'b0, shifted} - {2'b00, den_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            if (!diff[DEN_W+1]) begin
               rem_ff[i] <= diff[DEN_W-1:0];
            end else begin
               rem_ff[i] <= shifted[DEN_W-1:0];
            end
            quo_ff[i]  <= {quo_prev[NUM_W-2:0], ~diff[DEN_W+1]};
            num_ff[i]  <= {num_prev[NUM_W-2:0], 1'b0};
            den_ff[i]  <= den_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign quo      = quo_ff[NUM_W-1];
   assign side_out = side_ff[NUM_W-1];

endmodule

/* src/stick_deadzone_direction_buttons.sv */
// stick dead zone, radial rescale and direction flags, top level
// depends on sddb_pkg, sddb_sqrt, sddb_div and the assertion macro header
//
// Takes one stick sample per cycle and returns one result per sample in
// order. The stages are one input stage, a 16 stage square root, a
// scale and multiply stage, a 24 stage divider for the rescale, one sign
// stage, an 18 stage divider for the slopes and one output stage. The whole
// pipeline advances together; it holds when the result is not taken.
// Configuration writes are taken every cycle and must be made while no
// transaction is in flight.
module stick_deadzone_direction_buttons (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [sddb_pkg::COORD_W-1:0]     req_pad_x,
   input  logic signed [sddb_pkg::COORD_W-1:0]     req_pad_y,
   input  logic        [sddb_pkg::BTN_IN_W-1:0]    req_buttons_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [sddb_pkg::ADJ_W-1:0]       rsp_adjusted_x,
   output logic signed [sddb_pkg::ADJ_W-1:0]       rsp_adjusted_y,
   output logic        [sddb_pkg::BTN_W-1:0]       rsp_buttons_kept,
   output logic                                    rsp_dir_right,
   output logic                                    rsp_dir_left,
   output logic                                    rsp_dir_up,
   output logic                                    rsp_dir_down,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [sddb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [sddb_pkg::CSR_DAT_W-1:0]   csr_data
);
   import sddb_pkg::*;
   `include "stick_deadzone_direction_buttons_macros.svh"

   localparam int unsigned MAG_W    = 16;
   localparam int unsigned PROD_W   = 24;
   localparam int unsigned AX_W     = ADJ_W + 1;
   localparam int unsigned SNUM_W   = ADJ_W + 8;
   localparam int unsigned SQ_SIDE  = 2 * COORD_W + BTN_W + 2;
   localparam int unsigned D1_SIDE  = BTN_W + 1;
   localparam int unsigned D2_SIDE  = 2 * AX_W + BTN_W;
   localparam int unsigned LAT      = 1 + ROOT_W + 1 + PROD_W + 1 + SNUM_W + 1;

   // configuration
   logic [RADIUS_W-1:0] inner_ff, outer_ff;
   logic [SLOPE_W-1:0]  slope_ff;
   logic [LEN_W-1:0]    inner_sq_ff, outer_sq_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= INNER_RESET;
         outer_ff <= OUTER_RESET;
         slope_ff <= SLOPE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INNER: inner_ff <= csr_data[RADIUS_W-1:0];
            CSR_OUTER: outer_ff <= csr_data[RADIUS_W-1:0];
            CSR_SLOPE: slope_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      inner_sq_ff <= inner_ff * inner_ff;
      outer_sq_ff <= outer_ff * outer_ff;
   end

   // pipeline control
   logic           en;
   logic [LAT-1:0] vld_ff;

   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // input stage: clamp and squared length
   logic signed [COORD_W-1:0] x_in, y_in, x_ff, y_ff;
   logic [BTN_W-1:0]          btn_ff;
   logic [LEN_W-1:0]          len_in, len_ff;
   logic signed [LEN_W-1:0]   xx, yy;

   always_comb begin
      x_in = (req_pad_x == 9'sh100) ? -9'sd255 : req_pad_x;
      y_in = (req_pad_y == 9'sh100) ? -9'sd255 : req_pad_y;
      xx   = LEN_W'(x_in) * LEN_W'(x_in);
      yy   = LEN_W'(y_in) * LEN_W'(y_in);
      len_in = xx + yy;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         btn_ff <= req_buttons_in[BTN_W-1:0];
         len_ff <= len_in;
      end
   end

   // square root of len << 14 gives radius times 128
   logic [RAD_W-1:0]   radicand;
   logic [SQ_SIDE-1:0] sq_side_in, sq_side_out;
   logic [ROOT_W-1:0]  r128;

   assign radicand   = RAD_W'(len_ff) << LEN_SHIFT;
   assign sq_side_in = {x_ff, y_ff, btn_ff, (len_ff > inner_sq_ff), (len_ff >= outer_sq_ff)};

   sddb_sqrt #(.SIDE_W(SQ_SIDE)) u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (radicand),
      .side_in  (sq_side_in),
      .root     (r128),
      .side_out (sq_side_out)
   );

   // scale and multiply
   logic signed [COORD_W-1:0] sx, sy;
   logic [BTN_W-1:0]          s_btn;
   logic                      s_live, s_sat;
   logic signed [LEN_W-1:0]   scale;
   logic [LEN_W-1:0]          scale_abs;
   logic [MAG_W-1:0]          scale_mag;
   logic [COORD_W-2:0]        x_mag, y_mag;
   logic [PROD_W-1:0]         num_x_ff, num_y_ff;
   logic [ROOT_W-1:0]         den_ff;
   logic                      neg_x_ff, neg_y_ff;
   logic [BTN_W-1:0]          m_btn_ff;

   always_comb begin
      {sx, sy, s_btn, s_live, s_sat} = sq_side_out;
      if (s_sat) begin
         scale = (LEN_W'(outer_ff) - LEN_W'(inner_ff)) <<< R_SHIFT;
      end else begin
         scale = LEN_W'(r128) - (LEN_W'(inner_ff) << R_SHIFT);
      end
      scale_abs = scale[LEN_W-1] ? LEN_W'(-scale) : LEN_W'(scale);
      scale_mag = scale_abs[MAG_W-1:0];
      x_mag     = sx[COORD_W-1] ? (COORD_W-1)'(-sx) : sx[COORD_W-2:0];
      y_mag     = sy[COORD_W-1] ? (COORD_W-1)'(-sy) : sy[COORD_W-2:0];
   end

   // a centered stick has a zero root, so the divisor is kept nonzero
   always_ff @(posedge clock) begin
      if (en) begin
         num_x_ff <= s_live ? PROD_W'(x_mag * scale_mag) : '0;
         num_y_ff <= s_live ? PROD_W'(y_mag * scale_mag) : '0;
         den_ff   <= s_live ? r128 : ROOT_W'(1);
         neg_x_ff <= sx[COORD_W-1] ^ scale[LEN_W-1];
         neg_y_ff <= sy[COORD_W-1] ^ scale[LEN_W-1];
         m_btn_ff <= s_btn;
      end
   end

   // rescale divides
   logic [PROD_W-1:0]  qx, qy;
   logic [D1_SIDE-1:0] d1_side_out;
   logic               d2_side_out;

   sddb_div #(.NUM_W(PROD_W), .DEN_W(ROOT_W), .SIDE_W(D1_SIDE)) u_div_x (
      .clock    (clock),
      .en       (en),
      .num      (num_x_ff),
      .den      (den_ff),
      .side_in  ({m_btn_ff, neg_x_ff}),
      .quo      (qx),
      .side_out (d1_side_out)
   );

   sddb_div #(.NUM_W(PROD_W), .DEN_W(ROOT_W), .SIDE_W(1)) u_div_y (
      .clock    (clock),
      .en       (en),
      .num      (num_y_ff),
      .den      (den_ff),
      .side_in  (neg_y_ff),
      .quo      (qy),
      .side_out (d2_side_out)
   );

   // signs applied
   logic signed [AX_W-1:0] ax_ff, ay_ff;
   logic [BTN_W-1:0]       a_btn_ff;
   logic [ADJ_W-1:0]       ax_mag, ay_mag;

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff    <= d1_side_out[0] ? -$signed({1'b0, qx[ADJ_W-1:0]})
                                    : $signed({1'b0, qx[ADJ_W-1:0]});
         ay_ff    <= d2_side_out ? -$signed({1'b0, qy[ADJ_W-1:0]})
                                 : $signed({1'b0, qy[ADJ_W-1:0]});
         a_btn_ff <= d1_side_out[D1_SIDE-1:1];
      end
   end

   assign ax_mag = ax_ff[AX_W-1] ? ADJ_W'(-ax_ff) : ax_ff[ADJ_W-1:0];
   assign ay_mag = ay_ff[AX_W-1] ? ADJ_W'(-ay_ff) : ay_ff[ADJ_W-1:0];

   // slope divides
   logic [SNUM_W-1:0]  q_sy, q_tx;
   logic [D2_SIDE-1:0] sl_side_out;
   logic [AX_W-1:0]    sl_dummy;

   sddb_div #(.NUM_W(SNUM_W), .DEN_W(ADJ_W), .SIDE_W(D2_SIDE)) u_div_sy (
      .clock    (clock),
      .en       (en),
      .num      ({ay_mag, 8'd0}),
      .den      (ax_mag),
      .side_in  ({ax_ff, ay_ff, a_btn_ff}),
      .quo      (q_sy),
      .side_out (sl_side_out)
   );

   sddb_div #(.NUM_W(SNUM_W), .DEN_W(ADJ_W), .SIDE_W(AX_W)) u_div_tx (
      .clock    (clock),
      .en       (en),
      .num      ({ax_mag, 8'd0}),
      .den      (ay_mag),
      .side_in  (ax_ff),
      .quo      (q_tx),
      .side_out (sl_dummy)
   );

   // output stage
   logic signed [AX_W-1:0] f_ax, f_ay;
   logic [BTN_W-1:0]       f_btn;
   logic                   sy_ok, tx_ok;

   always_comb begin
      {f_ax, f_ay, f_btn} = sl_side_out;
      sy_ok = (q_sy <= SNUM_W'(slope_ff)) && (sl_dummy == f_ax);
      tx_ok = q_tx <= SNUM_W'(slope_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_adjusted_x   <= f_ax[ADJ_W-1:0];
         rsp_adjusted_y   <= f_ay[ADJ_W-1:0];
         rsp_buttons_kept <= f_btn;
         rsp_dir_right    <= !f_ax[AX_W-1] && (f_ax != '0) && sy_ok;
         rsp_dir_left     <= f_ax[AX_W-1] && sy_ok;
         rsp_dir_up       <= !f_ay[AX_W-1] && (f_ay != '0) && tx_ok;
         rsp_dir_down     <= f_ay[AX_W-1] && tx_ok;
      end
   end

   // checks
   `SDDB_CHECK(a_lr_excl, rsp_valid |-> !(rsp_dir_left && rsp_dir_right), "left and right both set")
   `SDDB_CHECK(a_x_zero, (rsp_valid && rsp_adjusted_x == '0) |-> !(rsp_dir_left || rsp_dir_right), "x flag with zero x")
   `SDDB_CHECK(a_y_zero, (rsp_valid && rsp_adjusted_y == '0) |-> !(rsp_dir_up || rsp_dir_down), "y flag with zero y")
   `SDDB_CHECK_ALWAYS(a_rst_idle, (!reset && $past(reset)) |-> !rsp_valid, "transaction out of reset")

endmodule
